>>> hdl/svm_pkg.sv
`timescale 1ns / 1ps

package svm_pkg;

  localparam int unsigned ADDR_W    = 17;
  localparam int unsigned SAMPLE_W  = 8;
  localparam int unsigned MIX_W     = 24;
  localparam int unsigned LEN_W     = 17;
  localparam int unsigned STEP_W    = 20;
  localparam int unsigned VOL_W     = 7;
  localparam int unsigned PAN_W     = 8;
  localparam int unsigned FUNC_W    = 2;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_W     = 20;
  localparam int unsigned SQ_W      = 18;
  localparam int unsigned GAIN_W    = 18;
  localparam int unsigned GV_W      = GAIN_W + VOL_W;
  localparam int unsigned PROD_W    = 33;
  localparam int unsigned IN_DATA_W  = 80;
  localparam int unsigned OUT_DATA_W = 56;

  localparam logic [VOL_W-1:0] VOL_FULL = 7'd64;
  localparam logic [MIX_W-1:0] MIX_MAX  = 24'h7F_FFFF;
  localparam logic [MIX_W-1:0] MIX_MIN  = 24'h80_0000;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_WRITE   = 2'd0,
    FUNC_RESTART = 2'd1,
    FUNC_RENDER  = 2'd2
  } svm_func_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SAMPLE_LENGTH = 3'd0,
    CFG_LOOP_START    = 3'd1,
    CFG_LOOP_LENGTH   = 3'd2,
    CFG_PHASE_STEP    = 3'd3,
    CFG_VOLUME        = 3'd4,
    CFG_PAN           = 3'd5
  } svm_cfg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_READ,
    ST_MUL,
    ST_SUM,
    ST_DONE
  } svm_state_e;

  // Stage enables from the sequencer to the mix datapath
  typedef struct packed {
    logic sq_en;
    logic gain_en;
    logic mul_en;
    logic sum_en;
  } svm_stage_t;

endpackage

>>> hdl/sample_voice_mixer.sv
`timescale 1ns / 1ps
// Sample write and restart transactions are accepted from idle and give no result.
// A render transaction walks check, read, multiply, sum and done after its accept cycle:
// pan square, registered sample read with gain times volume, sample multiply, round and
// saturate, output load. Done waits until the output register is free. A silent or
// stopping voice skips to done with the mix passed through; tready is high only in idle.
// Reset clears position, voice state, configuration and handshakes; memory is not cleared.

module sample_voice_mixer
  import svm_pkg::*;
#(
  parameter int unsigned SAMPLE_DEPTH  = 131072,
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // tdata: addr[16:0], sample_value[24:17], mix_left[48:25], mix_right[72:49]
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // tuser: func[1:0]
  input  logic [FUNC_W-1:0]     s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // tdata: mix_left_out[23:0], mix_right_out[47:24], playing[48]
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_W-1:0]      cfg_data_i
);

  localparam int unsigned PosW = ADDR_W + FRACTION_BITS;
  localparam int unsigned IdxW = $clog2(SAMPLE_DEPTH);

  logic [ADDR_W-1:0]   in_addr;
  logic [SAMPLE_W-1:0] in_sample;
  logic [MIX_W-1:0]    in_left, in_right;
  svm_func_e           in_func;

  assign in_addr   = s_axis_tdata[16:0];
  assign in_sample = s_axis_tdata[24:17];
  assign in_left   = s_axis_tdata[48:25];
  assign in_right  = s_axis_tdata[72:49];
  assign in_func   = svm_func_e'(s_axis_tuser);

  logic [LEN_W-1:0]  sample_length_q, loop_begin_q, loop_length_q;
  logic [STEP_W-1:0] phase_step_q;
  logic [VOL_W-1:0]  volume_q;
  logic [PAN_W-1:0]  pan_q;

  svm_state_e      state_q, state_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic            active_q, active_d;
  logic            out_valid_q, out_valid_d;
  logic            pass_q, pass_d;
  logic            in_range_q;

  logic [MIX_W-1:0] mix_left_q, mix_right_q;
  logic [MIX_W-1:0] out_left_q, out_right_q;
  logic             out_play_q;
  logic [MIX_W-1:0] dp_left, dp_right;

  logic             in_fire, load_out;
  logic [ADDR_W-1:0] pos_int;
  logic [LEN_W:0]    end_pos;
  logic              looping, at_end, idx_ok, wr_ok;
  logic [SAMPLE_W-1:0] rd_data;
  svm_stage_t        stage;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_fire     = s_axis_tvalid & s_axis_tready;
  assign cfg_ready_o = 1'b1;

  assign pos_int = pos_q[PosW-1:FRACTION_BITS];
  assign looping = (loop_length_q != '0);
  assign end_pos = looping ? ({1'b0, loop_begin_q} + {1'b0, loop_length_q})
                           : {1'b0, sample_length_q};
  assign at_end  = ({1'b0, pos_int} >= end_pos);
  assign idx_ok  = ({1'b0, pos_int} < 18'(SAMPLE_DEPTH));
  assign wr_ok   = ({1'b0, in_addr} < 18'(SAMPLE_DEPTH));

  always_comb begin
    state_d     = state_q;
    pos_d       = pos_q;
    active_d    = active_q;
    pass_d      = pass_q;
    load_out    = 1'b0;
    stage       = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          unique case (in_func)
            FUNC_RESTART: begin
              pos_d    = {in_addr, {FRACTION_BITS{1'b0}}};
              active_d = 1'b1;
            end
            FUNC_RENDER: begin
              state_d = ST_CHECK;
            end
            default: ;
          endcase
        end
      end
      ST_CHECK: begin
        stage.sq_en = 1'b1;
        pass_d      = 1'b0;
        if (!active_q || phase_step_q == '0) begin
          pass_d  = 1'b1;
          state_d = ST_DONE;
        end else if (at_end && !looping) begin
          // no loop: stop and let the mix through
          active_d = 1'b0;
          pass_d   = 1'b1;
          state_d  = ST_DONE;
        end else begin
          if (at_end) begin
            pos_d = {loop_begin_q, {FRACTION_BITS{1'b0}}};
          end
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        stage.gain_en = 1'b1;
        pos_d   = pos_q + {{(PosW-STEP_W){1'b0}}, phase_step_q};
        state_d = ST_MUL;
      end
      ST_MUL: begin
        stage.mul_en = 1'b1;
        state_d      = ST_SUM;
      end
      ST_SUM: begin
        stage.sum_en = 1'b1;
        state_d      = ST_DONE;
      end
      ST_DONE: begin
        // hold until the output register is free
        if (!out_valid_q || m_axis_tready) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
    out_valid_d = (out_valid_q & ~m_axis_tready) | load_out;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pos_q       <= '0;
      active_q    <= 1'b0;
      out_valid_q <= 1'b0;
      pass_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      pos_q       <= pos_d;
      active_q    <= active_d;
      out_valid_q <= out_valid_d;
      pass_q      <= pass_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_length_q <= '0;
      loop_begin_q    <= '0;
      loop_length_q   <= '0;
      phase_step_q    <= '0;
      volume_q        <= '0;
      pan_q           <= '0;
    end else if (cfg_valid_i) begin
      unique case (svm_cfg_e'(cfg_index_i))
        CFG_SAMPLE_LENGTH: sample_length_q <= cfg_data_i[LEN_W-1:0];
        CFG_LOOP_START:    loop_begin_q    <= cfg_data_i[LEN_W-1:0];
        CFG_LOOP_LENGTH:   loop_length_q   <= cfg_data_i[LEN_W-1:0];
        CFG_PHASE_STEP:    phase_step_q    <= cfg_data_i[STEP_W-1:0];
        CFG_VOLUME:        volume_q        <= cfg_data_i[VOL_W-1:0];
        CFG_PAN:           pan_q           <= cfg_data_i[PAN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && in_func == FUNC_RENDER) begin
      mix_left_q  <= in_left;
      mix_right_q <= in_right;
    end
    if (state_q == ST_READ) begin
      in_range_q <= idx_ok;
    end
    if (load_out) begin
      out_left_q  <= pass_q ? mix_left_q  : dp_left;
      out_right_q <= pass_q ? mix_right_q : dp_right;
      out_play_q  <= active_q;
    end
  end

  svm_sample_mem #(
    .DEPTH (SAMPLE_DEPTH),
    .IDX_W (IdxW)
  ) u_mem (
    .clk_i     (clk_i),
    .wr_en_i   (in_fire && in_func == FUNC_WRITE && wr_ok),
    .wr_idx_i  (in_addr[IdxW-1:0]),
    .wr_data_i (in_sample),
    .rd_en_i   (state_q == ST_READ && idx_ok),
    .rd_idx_i  (pos_int[IdxW-1:0]),
    .rd_data_o (rd_data)
  );

  svm_mix_dp u_dp (
    .clk_i       (clk_i),
    .stage_i     (stage),
    .pan_i       (pan_q),
    .volume_i    (volume_q),
    .smp_i       (rd_data),
    .smp_ok_i    (in_range_q),
    .mix_left_i  (mix_left_q),
    .mix_right_i (mix_right_q),
    .sum_left_o  (dp_left),
    .sum_right_o (dp_right)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'b0, out_play_q, out_right_q, out_left_q};

endmodule

>>> hdl/svm_sample_mem.sv
`timescale 1ns / 1ps

module svm_sample_mem
  import svm_pkg::*;
#(
  parameter int unsigned DEPTH  = 131072,
  parameter int unsigned IDX_W  = 17
) (
  input  logic                clk_i,
  input  logic                wr_en_i,
  input  logic [IDX_W-1:0]    wr_idx_i,
  input  logic [SAMPLE_W-1:0] wr_data_i,
  input  logic                rd_en_i,
  input  logic [IDX_W-1:0]    rd_idx_i,
  output logic [SAMPLE_W-1:0] rd_data_o
);

  logic [SAMPLE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_idx_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem[rd_idx_i];
    end
  end

endmodule

>>> hdl/svm_mix_dp.sv
`timescale 1ns / 1ps

module svm_mix_dp
  import svm_pkg::*;
(
  input  logic                clk_i,
  input  svm_stage_t          stage_i,
  input  logic [PAN_W-1:0]    pan_i,
  input  logic [VOL_W-1:0]    volume_i,
  input  logic [SAMPLE_W-1:0] smp_i,
  input  logic                smp_ok_i,
  input  logic [MIX_W-1:0]    mix_left_i,
  input  logic [MIX_W-1:0]    mix_right_i,
  output logic [MIX_W-1:0]    sum_left_o,
  output logic [MIX_W-1:0]    sum_right_o
);

  logic signed [9:0]  pan_a, pan_b;
  logic signed [19:0] sq_a_full, sq_b_full;
  logic [SQ_W-1:0]    sq_l_q, sq_r_q;

  logic [18:0]        gl_full, gr_full;
  logic [VOL_W-1:0]   vol_sat;
  logic [GV_W-1:0]    gv_l, gv_r;
  logic [GV_W-1:0]    gv_l_q, gv_r_q;

  logic signed [SAMPLE_W-1:0] smp;
  logic signed [GV_W:0]       gvs_l, gvs_r;
  logic signed [PROD_W:0]     prod_l_full, prod_r_full;
  logic [PROD_W-1:0]          prod_l_q, prod_r_q;

  logic [PROD_W:0]   rnd_l, rnd_r;
  logic [18:0]       con_l, con_r;
  logic [MIX_W:0]    sum_l, sum_r;
  logic [MIX_W-1:0]  sat_l, sat_r;

  // Square-law pan: gain numerator = 2^18 - (pan +/- 256)^2
  assign pan_a     = {{2{pan_i[PAN_W-1]}}, pan_i} + 10'sd256;
  assign pan_b     = {{2{pan_i[PAN_W-1]}}, pan_i} - 10'sd256;
  assign sq_a_full = pan_a * pan_a;
  assign sq_b_full = pan_b * pan_b;

  assign gl_full = 19'd262144 - {1'b0, sq_l_q};
  assign gr_full = 19'd262144 - {1'b0, sq_r_q};
  assign vol_sat = (volume_i > VOL_FULL) ? VOL_FULL : volume_i;
  assign gv_l    = GV_W'(gl_full[GAIN_W-1:0]) * GV_W'(vol_sat);
  assign gv_r    = GV_W'(gr_full[GAIN_W-1:0]) * GV_W'(vol_sat);

  assign smp         = smp_ok_i ? smp_i : '0;
  assign gvs_l       = {1'b0, gv_l_q};
  assign gvs_r       = {1'b0, gv_r_q};
  assign prod_l_full = smp * gvs_l;
  assign prod_r_full = smp * gvs_r;

  // Round to nearest, ties up: add half, then arithmetic shift by 15
  assign rnd_l = {prod_l_q[PROD_W-1], prod_l_q} + 34'd16384;
  assign rnd_r = {prod_r_q[PROD_W-1], prod_r_q} + 34'd16384;
  assign con_l = rnd_l[PROD_W:15];
  assign con_r = rnd_r[PROD_W:15];
  assign sum_l = {mix_left_i[MIX_W-1], mix_left_i} + {{6{con_l[18]}}, con_l};
  assign sum_r = {mix_right_i[MIX_W-1], mix_right_i} + {{6{con_r[18]}}, con_r};

  always_comb begin
    sat_l = sum_l[MIX_W-1:0];
    if (sum_l[MIX_W] != sum_l[MIX_W-1]) begin
      sat_l = sum_l[MIX_W] ? MIX_MIN : MIX_MAX;
    end
    sat_r = sum_r[MIX_W-1:0];
    if (sum_r[MIX_W] != sum_r[MIX_W-1]) begin
      sat_r = sum_r[MIX_W] ? MIX_MIN : MIX_MAX;
    end
  end

  always_ff @(posedge clk_i) begin
    if (stage_i.sq_en) begin
      sq_l_q <= sq_a_full[SQ_W-1:0];
      sq_r_q <= sq_b_full[SQ_W-1:0];
    end
    if (stage_i.gain_en) begin
      gv_l_q <= gv_l;
      gv_r_q <= gv_r;
    end
    if (stage_i.mul_en) begin
      prod_l_q <= prod_l_full[PROD_W-1:0];
      prod_r_q <= prod_r_full[PROD_W-1:0];
    end
    if (stage_i.sum_en) begin
      sum_left_o  <= sat_l;
      sum_right_o <= sat_r;
    end
  end

endmodule
